// ===== rtl/sha_pkg.sv =====
package sha_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned NumRounds = 64;
	localparam logic [7:0] PadMark = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       buf_wr;
		logic [7:0] buf_data;
		logic [5:0] buf_addr;
		logic       cnt_inc;
		logic       msg_clear;
		logic       load_vars;
		logic       round_en;
		logic       add_chain;
		logic       chain_init;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [5:0] rnd;
	} dp_stat_t;

	function automatic logic [31:0] round_const(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[t];
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
			32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
		return h[i];
	endfunction

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== rtl/sha256_stream_hasher_top.sv =====
// SHA-256 engine over a byte stream. Each accepted item carries one byte
// (when has_byte is set) and an end-of-message flag. Bytes are taken one per
// cycle while idle; the 64th byte of a block starts compression (one load,
// 64 rounds of the shared round unit, one chain add) during which no item is
// taken. A closing item pads one byte per cycle into the block buffer, then
// compresses one or two more blocks and emits the eight digest words, word 0
// first, one per accepted output item; the initial hash values are restored
// after the eighth word. Throughput is set by the single round unit.
module sha256_stream_hasher_top
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // has_byte
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast   // final_word
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [2:0]  sel;
	logic [31:0] digest;
	logic [63:0] msg_bits;

	sha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
		.in_has(s_tuser), .in_end(s_tlast), .stat, .msg_bits, .cmd,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_sel(sel)
	);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .out_sel(sel), .digest, .msg_bits
	);

	// Output item: digest word with its position; last flag on word seven.
	assign m_tdata = {5'd0, sel, digest};
	assign m_tlast = (sel == 3'd7);

	// No input item is taken while a digest is being shown.
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during digest output");
	// After the final word the index wraps and output stops.
	a_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output continued past final word");

endmodule

// ===== rtl/sha_datapath.sv =====
module sha_datapath
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [2:0]  out_sel,
	output logic [31:0] digest,
	output logic [63:0] msg_bits
);

	logic [31:0] buf_q [16];
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [63:0] bits_q;
	logic [31:0] w_new, t1, t2, x15, x2;

	// Block buffer held as sixteen big-endian words; a byte lands in its lane.
	always_ff @(posedge clk) begin
		if (cmd.buf_wr) begin
			buf_q[cmd.buf_addr[5:2]][{~cmd.buf_addr[1:0], 3'b000} +: 8] <= cmd.buf_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			rnd_q  <= '0;
		end else begin
			if (cmd.msg_clear) begin
				fill_q <= '0;
				bits_q <= '0;
			end else if (cmd.cnt_inc) begin
				fill_q <= fill_q + 6'd1;
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.round_en) rnd_q <= rnd_q + 6'd1;
			else if (cmd.load_vars) rnd_q <= '0;
		end
	end

	assign x15 = w_q[4'(rnd_q + 6'd1)];
	assign x2  = w_q[4'(rnd_q + 6'd14)];

	always_comb begin
		if (rnd_q < 6'd16) begin
			w_new = buf_q[rnd_q[3:0]];
		end else begin
			w_new = w_q[rnd_q[3:0]] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3))
				+ w_q[4'(rnd_q + 6'd9)] + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
		end
		t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_const(rnd_q) + w_new;
		t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.round_en) begin
			w_q[rnd_q[3:0]] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else if (cmd.chain_init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else if (cmd.add_chain) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	assign stat.fill = fill_q;
	assign stat.rnd  = rnd_q;
	assign digest    = h_q[out_sel];
	assign msg_bits  = bits_q;

endmodule

// ===== rtl/sha_ctrl.sv =====
module sha_ctrl
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_has,
	input  logic        in_end,
	input  dp_stat_t    stat,
	input  logic [63:0] msg_bits,
	output dp_cmd_t     cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_sel
);

	state_t     state_q, state_d;
	logic       final_q, final_d;  // current block is the last of the message
	logic       close_q, close_d;  // padding pending after this block
	logic [5:0] pos_q, pos_d;
	logic       two_q, two_d;      // length goes into a separate block
	logic [2:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
			close_q <= 1'b0;
			pos_q   <= '0;
			two_q   <= 1'b0;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
			close_q <= close_d;
			pos_q   <= pos_d;
			two_q   <= two_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		final_d  = final_q;
		close_d  = close_q;
		pos_d    = pos_q;
		two_d    = two_q;
		sel_d    = sel_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_has) begin
						cmd.buf_wr   = 1'b1;
						cmd.buf_data = in_byte;
						cmd.buf_addr = stat.fill;
						cmd.cnt_inc  = 1'b1;
					end
					close_d = in_end;
					final_d = 1'b0;
					if (in_has && stat.fill == 6'd63) begin
						state_d = ST_LOAD;
					end else if (in_end) begin
						state_d = ST_PAD;
						pos_d   = in_has ? stat.fill + 6'd1 : stat.fill;
					end
				end
			end
			ST_PAD: begin
				// Fill one byte per cycle: mark, zeros, length.
				cmd.buf_wr   = 1'b1;
				cmd.buf_addr = pos_q;
				if (close_q) begin
					cmd.buf_data = PadMark;
					close_d = 1'b0;
					two_d   = pos_q > 6'd55;
				end else if (pos_q >= 6'd56 && !two_q) begin
					cmd.buf_data = 8'(msg_bits >> (8 * (63 - 32'(pos_q))));
				end else begin
					cmd.buf_data = 8'h00;
				end
				pos_d = pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					state_d = ST_LOAD;
					final_d = !(close_q ? (pos_q > 6'd55) : two_q);
				end
			end
			ST_LOAD: begin
				cmd.load_vars = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (stat.rnd == 6'(NumRounds - 1)) state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_chain = 1'b1;
				if (final_q) begin
					state_d = ST_EMIT;
					sel_d = '0;
				end else if (close_q || two_q) begin
					state_d = ST_PAD;
					pos_d = close_q ? 6'd0 : 6'd0;
					two_d = 1'b0;
					if (close_q) pos_d = 6'd0;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					sel_d = sel_q + 3'd1;
					if (sel_q == 3'd7) begin
						cmd.chain_init = 1'b1;
						cmd.msg_clear  = 1'b1;
						final_d = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_sel = sel_q;

endmodule

// ===== test/tb_sha256_stream_hasher_top.sv =====
`timescale 1ns / 100ps

module tb_sha256_stream_hasher_top;
	import sha_pkg::*;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} digest_item_t;

	localparam logic [31:0] H0 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] KR [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
	localparam int LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	// Predictor state: a golden copy of the hasher
	logic [7:0]  blk [64];
	logic [5:0]  blk_fill;
	logic [63:0] bit_len;
	logic [31:0] chain [8];

	byte_item_t   pending_bytes[$];
	digest_item_t digest_due[$];
	int           errors = 0;
	int           cycles = 0;
	int           digests_seen = 0;
	int           items_sent = 0;
	bit           stall_req = 0;   // stimulus asks for one long receiver stall
	bit           stall_done = 0;
	int           hold_off = 0;

	sha256_stream_hasher_top DUT (.*);

	always #2 clk = ~clk;

	function automatic logic [31:0] rr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Run 64 rounds over the block buffer and fold into the chain
	task automatic compress_golden();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, t1, t2, x15, x2;
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			end else begin
				x15 = w[(t - 15) & 15];
				x2 = w[(t - 2) & 15];
				wt = w[t & 15] + (rr(x15, 7) ^ rr(x15, 18) ^ (x15 >> 3))
					+ w[(t - 7) & 15] + (rr(x2, 17) ^ rr(x2, 19) ^ (x2 >> 10));
			end
			w[t & 15] = wt;
			t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KR[t] + wt;
			t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] += v[i];
	endtask

	// Absorb one accepted item; on close, pad and queue the eight digest words
	task automatic hash_item(input byte_item_t it);
		int p;
		if (it.has_byte) begin
			blk[blk_fill] = it.data_byte;
			bit_len += 64'd8;
			blk_fill++;
			if (blk_fill == 0) compress_golden();
		end
		if (it.end_of_message) begin
			p = blk_fill;
			blk[p] = PadMark;
			p++;
			if (p > 56) begin
				while (p < 64) begin blk[p] = 8'h00; p++; end
				compress_golden();
				p = 0;
			end
			while (p < 56) begin blk[p] = 8'h00; p++; end
			for (int i = 0; i < 8; i++) blk[56 + i] = bit_len[63 - 8*i -: 8];
			compress_golden();
			for (int i = 0; i < 8; i++)
				digest_due.insert(digest_due.size(),
					digest_item_t'{chain[i], 3'(i), i == 7});
			for (int i = 0; i < 8; i++) chain[i] = H0[i];
			blk_fill = 0;
			bit_len = 0;
		end
	endtask

	task automatic queue_message(input int len, input bit close_with_byte);
		for (int i = 0; i < len; i++)
			pending_bytes.insert(pending_bytes.size(), byte_item_t'{8'($urandom), 1'b1,
				close_with_byte && (i == len - 1)});
		if (!close_with_byte || len == 0)
			pending_bytes.insert(pending_bytes.size(),
				byte_item_t'{8'($urandom), 1'b0, 1'b1});
	endtask

	// Driver: hold each item until taken, random gap before the next
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				hash_item(byte_item_t'{s_tdata, s_tuser, s_tlast});
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					{s_tdata, s_tuser, s_tlast} <= pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver stall, counted here once the stimulus asks for it
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_req && !stall_done) begin
				hold_off <= 400;
				stall_done <= 1'b1;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
			end
		end
	end

	// Monitor: compare each digest word with the oldest expectation
	int recv_gap = 0;
	always @(posedge clk) begin
		digest_item_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[31:0], m_tdata[34:32], m_tlast};
				digests_seen++;
				if (digest_due.size() == 0) begin
					$display("%0t: unexpected digest word %h", $time, got);
					errors++;
				end else begin
					want = digest_due.pop_front();
					if (got !== want || m_tdata[39:35] !== 5'b0) begin
						$display("%0t: mismatch expected %h actual %h (tdata %h)",
							$time, want, got, m_tdata);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready)
					recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int len;
		for (int i = 0; i < 8; i++) chain[i] = H0[i];
		blk_fill = 0;
		bit_len = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, single extremes, padding boundaries, idle item
		queue_message(0, 0);
		pending_bytes.insert(pending_bytes.size(), byte_item_t'{8'hff, 1'b0, 1'b0});
		pending_bytes.insert(pending_bytes.size(), byte_item_t'{8'h00, 1'b1, 1'b1});
		pending_bytes.insert(pending_bytes.size(), byte_item_t'{8'hff, 1'b1, 1'b1});
		queue_message(55, 1);
		queue_message(56, 0);
		queue_message(64, 1);
		// Stall the receiver while a burst of short messages arrives
		stall_req = 1'b1;
		for (int i = 0; i < 4; i++) queue_message(2, 1);
		wait (pending_bytes.size() == 0 && digest_due.size() == 0);

		// Random: mostly short messages, a few long, some idle noise
		while (items_sent < 380) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 140) : $urandom_range(0, 12);
			if ($urandom_range(0, 4) == 0)
				pending_bytes.insert(pending_bytes.size(),
					byte_item_t'{8'($urandom), 1'b0, 1'b0});
			queue_message(len, $urandom_range(0, 1));
			wait (pending_bytes.size() == 0);
		end

		wait (digest_due.size() == 0 && !s_tvalid);
		repeat (200) @(posedge clk);
		$display("Covered %0d items and %0d digest words, incl. empty, pad-overflow",
			items_sent, digests_seen);
		$display("and full-block messages under random stalls and a long output hold-off.");
		if (errors == 0 && digest_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== sha256_stream_hasher_top.f =====
rtl/sha_pkg.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_stream_hasher_top.sv
test/tb_sha256_stream_hasher_top.sv
